// ===== hdl/abbreviated_command_lookup_top_defines.svh =====
// Assertion macros shared by the abbreviated command lookup checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ABBREVIATED_COMMAND_LOOKUP_TOP_DEFINES_SVH
`define ABBREVIATED_COMMAND_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/acl_pkg.sv =====
// Package for the abbreviated command lookup block: types, constants, states.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package acl_pkg;

    localparam int TABLE_ENTRIES_DEF = 512;
    localparam int NAME_BYTES_DEF    = 16;
    localparam int ADDR_MAX_W        = 12;   // enough for 4096 table entries
    localparam int LEN_W             = 5;
    localparam int NAME_W            = 128;
    localparam int IN_DATA_W         = 152;
    localparam int OUT_DATA_W        = 16;
    localparam int CFG_W             = 10;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // One table entry as it travels along the row of byte cells.
    typedef struct packed {
        logic                  valid;
        logic [ADDR_MAX_W-1:0] idx;
        logic [LEN_W-1:0]      req;
        logic [LEN_W-1:0]      full;
        logic [NAME_W-1:0]     name;
        logic                  ok;
        logic                  run;
        logic [LEN_W-1:0]      score;
    } cell_bus_t;

endpackage

// ===== hdl/acl_table.sv =====
// Entry table of the abbreviated command lookup: one write port, one registered read port.
// Depends on acl_pkg for the cell bus type.
`timescale 1ns / 1ps

module acl_table
    import acl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int AW            = $clog2(TABLE_ENTRIES)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [NAME_W-1:0]     wr_name,
    input  logic [LEN_W-1:0]      wr_req,
    input  logic [LEN_W-1:0]      wr_full,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output cell_bus_t             rd_bus
);

    localparam int WORD_W = NAME_W + 2 * LEN_W;

    logic [WORD_W-1:0] mem [0:TABLE_ENTRIES-1];
    logic [WORD_W-1:0] rd_word_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic              rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_name, wr_full, wr_req};
        end
        rd_word_reg <= mem[rd_addr];
        rd_addr_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
        end
    end

    always_comb
    begin
        rd_bus       = '0;
        rd_bus.valid = rd_valid_reg;
        rd_bus.idx   = ADDR_MAX_W'(rd_addr_reg);
        rd_bus.req   = rd_word_reg[LEN_W-1:0];
        rd_bus.full  = rd_word_reg[2*LEN_W-1:LEN_W];
        rd_bus.name  = rd_word_reg[WORD_W-1:2*LEN_W];
        rd_bus.ok    = 1'b1;
        rd_bus.run   = 1'b1;
        rd_bus.score = '0;
    end

endmodule

// ===== hdl/acl_cell.sv =====
// One byte cell of the compare row: checks byte POS of an entry against the key.
// Depends on acl_pkg for the cell bus type.
`timescale 1ns / 1ps

module acl_cell
    import acl_pkg::*;
#(
    parameter int POS = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_bus_t        in_bus,
    input  logic [7:0]       key_byte,
    input  logic [LEN_W-1:0] key_len,
    output cell_bus_t        out_bus
);

    localparam logic [LEN_W-1:0] POS_L  = LEN_W'(POS);
    localparam logic [LEN_W-1:0] POS_P1 = LEN_W'(POS + 1);

    cell_bus_t  bus_next;
    cell_bus_t  bus_reg;
    logic       valid_reg;
    logic       byte_eq;
    logic       extend;

    always_comb
    begin
        byte_eq  = (in_bus.name[8*POS +: 8] == key_byte);
        extend   = 1'b0;
        bus_next = in_bus;
        if (POS_L < in_bus.req)
        begin
            // Still inside the mandatory prefix: every byte must agree.
            bus_next.ok    = in_bus.ok & byte_eq;
            bus_next.score = POS_P1;
        end
        else
        begin
            extend = in_bus.run && (POS_L < in_bus.full) && (POS_L < key_len) && byte_eq;
            bus_next.run   = extend;
            bus_next.score = in_bus.score + LEN_W'(extend);
        end
    end

    always_ff @(posedge clk)
    begin
        bus_reg <= bus_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= bus_next.valid;
        end
    end

    always_comb
    begin
        out_bus       = bus_reg;
        out_bus.valid = valid_reg;
    end

endmodule

// ===== hdl/abbreviated_command_lookup_top.sv =====
// Abbreviated command lookup, usage notes.
// Slave stream (s_*): one beat per request. tuser selects a table write or a key lookup.
// Master stream (m_*): one beat per lookup with found, index, score and whole-key flag;
// a write produces no beat. Config channel (cfg_*): writes entry_count, always ready,
// and is to be used only while the block is idle.
// After a write beat the block stays idle and is ready again in the next cycle.
// A lookup streams the first min(entry_count, TABLE_ENTRIES) entries out of the table
// RAM, one per cycle, through a row of NAME_BYTES byte-compare cells and a best-match
// register; the result beat becomes valid once the scan is over and the cell row has
// drained (an empty table skips the scan). The single table read port limits the
// scan to one entry per cycle.
// s_tready is low from a lookup beat until its result beat has been taken, so a
// stalled receiver holds the result steady and blocks further requests.
// Reset clears control state and entry_count; the table itself is not cleared, and
// slots below entry_count must be written before a lookup.
`timescale 1ns / 1ps

module abbreviated_command_lookup_top
    import acl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int NAME_BYTES    = NAME_BYTES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [8:0] entry_index, [72:9] text_low, [136:73] text_high,
    // [141:137] required_length, [146:142] text_length, rest zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,   // [0] req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] found, [9:1] match_index, [14:10] matched_length, [15] whole_key_matched
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int AW      = $clog2(TABLE_ENTRIES);
    localparam int CW      = $clog2(TABLE_ENTRIES + 1);
    localparam int DRAIN_N = NAME_BYTES + 2;
    localparam int DW      = $clog2(DRAIN_N + 1);
    localparam logic [LEN_W-1:0] NB_L = LEN_W'(NAME_BYTES);

    state_t               state_reg, state_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        scan_reg, scan_next;
    logic [DW-1:0]        drain_reg, drain_next;
    logic [NAME_W-1:0]    key_reg;
    logic [LEN_W-1:0]     key_len_reg;

    logic                 found_reg;
    logic [ADDR_MAX_W-1:0] best_idx_reg;
    logic [LEN_W-1:0]     best_score_reg;
    logic [LEN_W-1:0]     best_req_reg;

    logic                 s_accept;
    logic                 wr_en;
    logic [31:0]          slot_wide;
    logic [31:0]          cfg_wide;
    logic [LEN_W-1:0]     in_req_raw, in_len_raw;
    logic [LEN_W-1:0]     in_req_sat, in_len_sat, wr_req, wr_full;
    logic                 rd_en;
    logic                 qualify;
    logic                 better;

    cell_bus_t            chain [0:NAME_BYTES];

    assign s_accept   = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign in_req_raw = s_tdata[141:137];
    assign in_len_raw = s_tdata[146:142];
    assign in_req_sat = (in_req_raw > NB_L) ? NB_L : in_req_raw;
    assign in_len_sat = (in_len_raw > NB_L) ? NB_L : in_len_raw;
    assign wr_req     = (in_req_sat == '0) ? LEN_W'(1) : in_req_sat;
    assign wr_full    = (in_len_sat < wr_req) ? wr_req : in_len_sat;
    assign slot_wide  = 32'(s_tdata[8:0]);
    assign cfg_wide   = 32'(cfg_data);
    assign wr_en      = s_accept && (s_tuser == REQ_WRITE) && (slot_wide < 32'(TABLE_ENTRIES));
    assign rd_en      = (state_reg == ST_SCAN);

    acl_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .AW            (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (slot_wide[AW-1:0]),
        .wr_name (s_tdata[136:9]),
        .wr_req  (wr_req),
        .wr_full (wr_full),
        .rd_en   (rd_en),
        .rd_addr (scan_reg[AW-1:0]),
        .rd_bus  (chain[0])
    );

    for (genvar k = 0; k < NAME_BYTES; k++)
    begin : g_cell
        acl_cell #(
            .POS (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_bus   (chain[k]),
            .key_byte (key_reg[8*k +: 8]),
            .key_len  (key_len_reg),
            .out_bus  (chain[k+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
            drain_reg <= drain_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= (cfg_wide > 32'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES)
                                                             : CW'(cfg_wide);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        drain_next = drain_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && (s_tuser == REQ_LOOKUP))
                begin
                    scan_next  = '0;
                    drain_next = DW'(DRAIN_N);
                    state_next = (count_reg == '0) ? ST_DRAIN : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_next = scan_reg + CW'(1);
                if (scan_next == count_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg - DW'(1);
                if (drain_reg == '0)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Best-match register at the end of the cell row.
    always_comb
    begin
        qualify = chain[NAME_BYTES].valid && chain[NAME_BYTES].ok
                  && (chain[NAME_BYTES].req <= key_len_reg);
        better  = !found_reg || (chain[NAME_BYTES].score > best_score_reg)
                  || ((chain[NAME_BYTES].score == best_score_reg)
                      && (chain[NAME_BYTES].req < best_req_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (s_accept && (s_tuser == REQ_LOOKUP))
        begin
            found_reg <= 1'b0;
        end
        else if (qualify)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept && (s_tuser == REQ_LOOKUP))
        begin
            key_reg        <= s_tdata[136:9];
            key_len_reg    <= in_len_sat;
            best_idx_reg   <= '0;
            best_score_reg <= '0;
            best_req_reg   <= '0;
        end
        else if (qualify && better)
        begin
            best_idx_reg   <= chain[NAME_BYTES].idx;
            best_score_reg <= chain[NAME_BYTES].score;
            best_req_reg   <= chain[NAME_BYTES].req;
        end
    end

    assign m_tdata = {found_reg && (best_score_reg == key_len_reg),
                      best_score_reg,
                      best_idx_reg[8:0],
                      found_reg};

endmodule

// ===== hdl/acl_checker.sv =====
// Port-level checker for the abbreviated command lookup, bound to the top level.
// Depends on acl_pkg and the assertion macros in abbreviated_command_lookup_top_defines.svh.
`timescale 1ns / 1ps
`include "abbreviated_command_lookup_top_defines.svh"

module acl_checker
    import acl_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    `ACL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result beat changed while stalled")
    `ACL_ASSERT_IMP(a_whole_needs_found, m_tvalid && m_tdata[15], m_tdata[0], "whole key flag without a match")
    `ACL_ASSERT_IMP(a_miss_zero, m_tvalid && !m_tdata[0], m_tdata[14:1] == '0, "miss result carries nonzero fields")
    `ACL_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready, "request taken while a result is pending")
    `ACL_ASSERT_NEXT(a_lookup_busy, s_tvalid && s_tready && (s_tuser == REQ_LOOKUP), !s_tready, "ready after lookup beat")

endmodule

bind abbreviated_command_lookup_top acl_checker u_acl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/abbreviated_command_lookup_top_tb.sv =====
// Self-checking testbench for abbreviated_command_lookup_top: table writes, key lookups
// and entry_count settings checked against an in-bench prediction of the best match.
// Depends on acl_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module abbreviated_command_lookup_top_tb;
    import acl_pkg::*;

    localparam int ENTRIES    = 512;
    localparam int NBYTES     = 16;
    localparam int CYCLE_LIMIT = 3000000;

    // Laid out as m_tdata: found in bit 0, whole-key flag in bit 15.
    typedef struct packed {
        logic       whole;
        logic [4:0] length;
        logic [8:0] index;
        logic       found;
    } match_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;

    // Shadow of the table and the register.
    logic [127:0] table_name [ENTRIES];
    logic [4:0]   table_req  [ENTRIES];
    logic [4:0]   table_full [ENTRIES];
    int           active_count;

    match_t match_q [$];
    int     errors;
    int     cycles;
    int     hold_off;
    bit     quiet;

    abbreviated_command_lookup_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int clip_len(input logic [4:0] raw);
        return (raw > NBYTES) ? NBYTES : int'(raw);
    endfunction

    function automatic match_t predict_lookup(input logic [127:0] key, input logic [4:0] raw_len);
        match_t best;
        int     key_len;
        int     limit;
        int     req;
        int     k;
        int     best_req;
        bit     ok;
        best     = '0;
        best_req = 0;
        key_len  = clip_len(raw_len);
        limit    = (active_count > ENTRIES) ? ENTRIES : active_count;
        for (int i = 0; i < limit; i++)
        begin
            req = table_req[i];
            if (req > key_len)
                continue;
            ok = 1'b1;
            for (k = 0; k < req; k++)
                if (table_name[i][8*k +: 8] != key[8*k +: 8])
                    ok = 1'b0;
            if (!ok)
                continue;
            k = req;
            while (k < table_full[i] && k < key_len && table_name[i][8*k +: 8] == key[8*k +: 8])
                k++;
            if (!best.found || k > best.length || (k == best.length && req < best_req))
            begin
                best.found  = 1'b1;
                best.index  = i[8:0];
                best.length = k[4:0];
                best_req    = req;
            end
        end
        best.whole = best.found && (best.length == key_len);
        return best;
    endfunction

    task automatic pause_random();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (quiet || r < 70)
            n = 0;
        else if (r < 95)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Sends one beat and records its effect on the shadow table or the expected queue.
    task automatic send_beat(input logic kind, input logic [8:0] slot, input logic [127:0] text,
                             input logic [4:0] req_raw, input logic [4:0] len_raw);
        int req;
        int full;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, len_raw, req_raw, text[127:64], text[63:0], slot};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind == REQ_WRITE)
        begin
            req  = clip_len(req_raw);
            if (req == 0)
                req = 1;
            full = clip_len(len_raw);
            if (full < req)
                full = req;
            table_name[slot] = text;
            table_req[slot]  = req[4:0];
            table_full[slot] = full[4:0];
        end
        else
            match_q.push_back(predict_lookup(text, len_raw));
        pause_random();
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (match_q.size() != 0)
            @(posedge clk);
        repeat (NBYTES + 10) @(posedge clk);
    endtask

    task automatic set_count(input int value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value[CFG_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        active_count = value & 10'h3FF;
        @(posedge clk);
    endtask

    function automatic logic [127:0] letter_text();
        logic [127:0] t;
        for (int i = 0; i < NBYTES; i++)
            t[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 3));
        return t;
    endfunction

    function automatic logic [127:0] noise_text();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        int r;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            else if (!quiet && r < 20)
            begin
                m_tready <= 1'b0;
                repeat ((r < 3) ? $urandom_range(10, 60) : $urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        match_t got;
        match_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (match_q.size() == 0)
            begin
                $error("result beat with no lookup outstanding: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = match_q.pop_front();
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    errors++;
                end
                if (got.index !== want.index)
                begin
                    $error("match_index: expected %0d, got %0d", want.index, got.index);
                    errors++;
                end
                if (got.length !== want.length)
                begin
                    $error("matched_length: expected %0d, got %0d", want.length, got.length);
                    errors++;
                end
                if (got.whole !== want.whole)
                begin
                    $error("whole_key_matched: expected %0d, got %0d", want.whole, got.whole);
                    errors++;
                end
            end
        end
    end

    // Every slot is written first so no lookup ever reads an unwritten entry.
    task automatic test_fill_table();
        int req;
        for (int i = 0; i < ENTRIES; i++)
        begin
            req = $urandom_range(1, 6);
            send_beat(REQ_WRITE, i[8:0], letter_text(), req[4:0],
                      5'($urandom_range(req, NBYTES)));
        end
    endtask

    task automatic test_directed();
        logic [127:0] name;
        set_count(0);
        send_beat(REQ_LOOKUP, 9'd0, letter_text(), 5'd0, 5'd16);  // empty table
        set_count(1023);                                           // saturates at table size
        send_beat(REQ_LOOKUP, 9'd0, table_name[511], 5'd0, 5'd31);
        send_beat(REQ_LOOKUP, 9'd0, table_name[3], 5'd0, 5'd0);   // empty key
        set_count(4);
        name = "zzzzzzzzzzfedcba";
        // Equal scores: the entry with the shorter required part wins over the lower index.
        send_beat(REQ_WRITE, 9'd0, name, 5'd4, 5'd6);
        send_beat(REQ_WRITE, 9'd1, name, 5'd2, 5'd6);
        send_beat(REQ_LOOKUP, 9'd0, name, 5'd0, 5'd6);
        send_beat(REQ_LOOKUP, 9'd0, name, 5'd0, 5'd9);
        send_beat(REQ_LOOKUP, 9'd0, name, 5'd0, 5'd1);
        // Required length of zero is stored as one; a short name gets an empty tail.
        send_beat(REQ_WRITE, 9'd2, {128{1'b1}}, 5'd0, 5'd0);
        send_beat(REQ_LOOKUP, 9'd0, {128{1'b1}}, 5'd0, 5'd16);
        // Lengths above the name size saturate.
        send_beat(REQ_WRITE, 9'd3, '0, 5'd31, 5'd31);
        send_beat(REQ_LOOKUP, 9'd0, '0, 5'd0, 5'd31);
        send_beat(REQ_LOOKUP, 9'd0, '0, 5'd0, 5'd15);
        send_beat(REQ_WRITE, 9'd511, {128{1'b1}}, 5'd17, 5'd3);
        set_count(512);
        send_beat(REQ_LOOKUP, 9'd0, {128{1'b1}}, 5'd0, 5'd16);
    endtask

    task automatic test_receiver_hold();
        set_count(8);
        hold_off = 400;
        for (int i = 0; i < 6; i++)
            send_beat(REQ_LOOKUP, 9'd0, table_name[$urandom_range(0, 7)], 5'd0,
                      5'($urandom_range(1, 16)));
    endtask

    task automatic test_random_phase(input int count, input int items, input bit still);
        int           r;
        int           slot;
        logic [127:0] key;
        set_count(count);
        quiet = still;
        for (int n = 0; n < items; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                slot = $urandom_range(0, ENTRIES - 1);
                send_beat(REQ_WRITE, slot[8:0], (r < 4) ? noise_text() : letter_text(),
                          5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            end
            else if (r < 30)
                send_beat(REQ_LOOKUP, 9'($urandom), (r < 22) ? noise_text() : letter_text(),
                          5'($urandom), 5'($urandom));
            else
            begin
                slot = $urandom_range(0, (count > 0 && count < ENTRIES) ? count - 1 : ENTRIES - 1);
                key  = table_name[slot];
                if ($urandom_range(0, 3) == 0)
                    key[8*$urandom_range(0, NBYTES - 1) +: 8] = 8'h61 + 8'($urandom_range(0, 3));
                send_beat(REQ_LOOKUP, 9'($urandom), key, 5'($urandom),
                          5'($urandom_range(1, NBYTES)));
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        errors    = 0;
        cycles    = 0;
        hold_off  = 0;
        quiet     = 1'b0;
        active_count = 0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_table();
        test_directed();
        test_receiver_hold();
        test_random_phase(1, 150, 1'b0);
        test_random_phase(3, 150, 1'b1);
        test_random_phase(16, 200, 1'b0);
        test_random_phase(40, 200, 1'b0);
        test_random_phase(0, 40, 1'b0);
        test_random_phase(512, 80, 1'b0);
        test_random_phase(1023, 40, 1'b0);
        test_random_phase(100, 150, 1'b0);

        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/acl_pkg.sv
hdl/acl_table.sv
hdl/acl_cell.sv
hdl/abbreviated_command_lookup_top.sv
hdl/acl_checker.sv
test/abbreviated_command_lookup_top_tb.sv
